### hdl/shp_pkg.sv
`timescale 1ns / 1ps
// Song header parser package: command, event and sequencer codes, constants.
// No dependencies; used by the interfaces, the divider and the top level.
package shp_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_NOTE  = 3'd1,
        CMD_CHAN  = 3'd2,
        CMD_TEMPO = 3'd3,
        CMD_VOL   = 3'd4,
        CMD_PROG  = 3'd5,
        CMD_VELO  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        EV_CHAN  = 2'd0,
        EV_TEMPO = 2'd1,
        EV_VELO  = 2'd2,
        EV_END   = 2'd3
    } t_event;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam int BYTE_W  = 8;
    localparam int TICKS_W = 12;
    localparam int VOL_W   = 4;

    localparam logic [TICKS_W-1:0] TICK_BASE = 12'd2400;
    localparam int                 DIV_STEPS = TICKS_W;

    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'hFF;
    localparam logic [BYTE_W-1:0] NOTE_MASK  = 8'h9F;
    localparam logic [BYTE_W-1:0] NOTE_LIMIT = 8'h20;

    localparam logic [BYTE_W-1:0] OP_CHAN  = 8'h80;
    localparam logic [BYTE_W-1:0] OP_TEMPO = 8'h81;
    localparam logic [BYTE_W-1:0] OP_VOL   = 8'h83;
    localparam logic [BYTE_W-1:0] OP_PROG  = 8'hC0;
    localparam logic [BYTE_W-1:0] OP_VELO  = 8'h84;

    localparam logic [BYTE_W-1:0] VEL_T0 = 8'h17;
    localparam logic [BYTE_W-1:0] VEL_T1 = 8'h27;
    localparam logic [BYTE_W-1:0] VEL_T2 = 8'h37;
    localparam logic [BYTE_W-1:0] VEL_T3 = 8'h57;
    localparam logic [BYTE_W-1:0] VEL_T4 = 8'h67;

    localparam logic [VOL_W-1:0] VB_0 = 4'd5;
    localparam logic [VOL_W-1:0] VB_1 = 4'd7;
    localparam logic [VOL_W-1:0] VB_2 = 4'd9;
    localparam logic [VOL_W-1:0] VB_3 = 4'd11;
    localparam logic [VOL_W-1:0] VB_4 = 4'd13;

endpackage

### hdl/shp_in_if.sv
`timescale 1ns / 1ps
// Input word channel: one header byte and its first flag per word.
// Depends on shp_pkg for widths.
interface shp_in_if;
    logic                        valid;
    logic                        ready;
    logic [shp_pkg::BYTE_W-1:0]  header_byte;
    logic                        first;

    modport source (output valid, output header_byte, output first, input ready);
    modport sink   (input valid, input header_byte, input first, output ready);
endinterface

### hdl/shp_out_if.sv
`timescale 1ns / 1ps
// Output word channel: one parsed header event per word.
// Depends on shp_pkg for the event code type and widths.
interface shp_out_if;
    logic                        valid;
    logic                        ready;
    shp_pkg::t_event             event_code;
    logic [shp_pkg::BYTE_W-1:0]  value;
    logic [shp_pkg::TICKS_W-1:0] ticks_per_beat;
    logic                        tempo_zero;
    logic [shp_pkg::VOL_W-1:0]   volume_bucket;

    modport source (output valid, output event_code, output value, output ticks_per_beat,
                    output tempo_zero, output volume_bucket, input ready);
    modport sink   (input valid, input event_code, input value, input ticks_per_beat,
                    input tempo_zero, input volume_bucket, output ready);
endinterface

### hdl/song_header_command_parser.sv
`timescale 1ns / 1ps
// Song header command parser: reads header bytes, reports channel count,
// tempo with ticks per beat, velocity bucket and header end.
// Depends on shp_pkg, shp_in_if, shp_out_if and shp_div.
//
// Usage:
//   i_in is the byte channel (header_byte, first), o_out the event channel.
//   A word moves when valid and ready are both high at a rising edge.
//   An event from any byte but a nonzero tempo lands in the output
//   register the cycle after its byte is taken.
//   The last byte of a tempo record with a nonzero tempo starts the
//   restoring divider, which makes one quotient bit per cycle; its event
//   is loaded once the divider is done and the output register is free,
//   and no byte is taken meanwhile.
//   The output register holds one event. A byte is taken while it is
//   empty or being read in the same cycle; when the receiver stalls with
//   an event held, i_in.ready stays low and the event holds steady.
//   Reset (i_rst_n low at a clock edge) drops any header in progress,
//   clears the held volume bucket and empties the output register.
module song_header_command_parser (
    input  logic i_clk,
    input  logic i_rst_n,
    shp_in_if.sink    i_in,
    shp_out_if.source o_out
);
    shp_pkg::t_state             r_state, n_state;
    logic                        r_active, n_active;
    logic                        r_at_first, n_at_first;
    shp_pkg::t_cmd               r_cmd, n_cmd;
    logic [1:0]                  r_pos, n_pos;
    logic [shp_pkg::VOL_W-1:0]   r_vol, n_vol;
    logic [shp_pkg::BYTE_W-1:0]  r_tempo;

    logic                        r_o_valid;
    shp_pkg::t_event             r_o_code;
    logic [shp_pkg::BYTE_W-1:0]  r_o_value;
    logic [shp_pkg::TICKS_W-1:0] r_o_ticks;
    logic                        r_o_tz;
    logic [shp_pkg::VOL_W-1:0]   r_o_vol;

    logic                        w_ready;
    logic                        w_accept;
    logic                        w_slot_free;
    logic                        w_emit;
    logic                        w_div;
    shp_pkg::t_event             w_code;
    logic [shp_pkg::BYTE_W-1:0]  w_value;
    logic                        w_tz;
    shp_pkg::t_cmd               w_cmd_was;
    logic [1:0]                  w_pos_inc;
    logic                        w_last;
    logic                        w_skip;
    logic [shp_pkg::BYTE_W-1:0]  w_masked;
    logic [shp_pkg::BYTE_W-1:0]  w_b;
    logic                        w_load_step;
    logic                        w_load_div;
    logic                        w_div_start;
    logic [shp_pkg::TICKS_W-1:0] w_quot;
    shp_pkg::t_div_stat          w_div_stat;

    assign w_b         = i_in.header_byte;
    assign w_slot_free = !r_o_valid || o_out.ready;
    assign w_accept    = i_in.valid && w_ready;
    assign w_masked    = w_b & shp_pkg::NOTE_MASK;

    // Parse one byte against the held record state.
    always_comb begin
        n_active   = r_active;
        n_at_first = r_at_first;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_vol      = r_vol;
        w_emit     = 1'b0;
        w_div      = 1'b0;
        w_code     = shp_pkg::EV_END;
        w_value    = '0;
        w_tz       = 1'b0;
        w_cmd_was  = shp_pkg::CMD_NONE;
        w_pos_inc  = '0;
        w_last     = 1'b0;
        w_skip     = 1'b0;
        if (i_in.first) begin
            n_active   = 1'b1;
            n_at_first = 1'b1;
            n_cmd      = shp_pkg::CMD_NONE;
            n_pos      = '0;
        end
        if (n_active) begin
            if (n_cmd != shp_pkg::CMD_NONE) begin
                w_cmd_was = n_cmd;
                w_pos_inc = n_pos + 2'd1;
                if (w_cmd_was == shp_pkg::CMD_TEMPO || w_cmd_was == shp_pkg::CMD_VOL) begin
                    w_last = (w_pos_inc >= 2'd1);
                end else begin
                    w_last = (w_pos_inc >= 2'd2);
                end
                if (!w_last) begin
                    n_pos = w_pos_inc;
                end else begin
                    n_cmd = shp_pkg::CMD_NONE;
                    n_pos = '0;
                    case (w_cmd_was)
                        shp_pkg::CMD_CHAN: begin
                            w_emit  = 1'b1;
                            w_code  = shp_pkg::EV_CHAN;
                            w_value = w_b;
                        end
                        shp_pkg::CMD_TEMPO: begin
                            w_emit = 1'b1;
                            w_code = shp_pkg::EV_TEMPO;
                            if (w_b == shp_pkg::BYTE_ZERO) begin
                                w_tz = 1'b1;
                            end else begin
                                w_value = w_b;
                                w_div   = 1'b1;
                            end
                        end
                        shp_pkg::CMD_VELO: begin
                            w_emit  = 1'b1;
                            w_code  = shp_pkg::EV_VELO;
                            w_value = w_b;
                            if (w_b < shp_pkg::VEL_T0) begin
                                n_vol = shp_pkg::VB_0;
                            end else if (w_b < shp_pkg::VEL_T1) begin
                                n_vol = shp_pkg::VB_1;
                            end else if (w_b < shp_pkg::VEL_T2) begin
                                n_vol = shp_pkg::VB_2;
                            end else if (w_b < shp_pkg::VEL_T3) begin
                                n_vol = shp_pkg::VB_3;
                            end else if (w_b < shp_pkg::VEL_T4) begin
                                n_vol = shp_pkg::VB_4;
                            end
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
            end else begin
                if (n_at_first) begin
                    n_at_first = 1'b0;
                    w_skip     = (w_b == shp_pkg::BYTE_ZERO);
                end
                if (!w_skip) begin
                    if (w_b == shp_pkg::BYTE_ZERO || w_b == shp_pkg::BYTE_END) begin
                        n_active = 1'b0;
                        n_cmd    = shp_pkg::CMD_NONE;
                        n_pos    = '0;
                        w_emit   = 1'b1;
                        w_code   = shp_pkg::EV_END;
                    end else begin
                        n_pos = '0;
                        if (w_masked != shp_pkg::BYTE_ZERO && w_masked < shp_pkg::NOTE_LIMIT) begin
                            n_cmd = shp_pkg::CMD_NOTE;
                        end else if (w_b == shp_pkg::OP_CHAN) begin
                            n_cmd = shp_pkg::CMD_CHAN;
                        end else if (w_b == shp_pkg::OP_TEMPO) begin
                            n_cmd = shp_pkg::CMD_TEMPO;
                        end else if (w_b == shp_pkg::OP_VOL) begin
                            n_cmd = shp_pkg::CMD_VOL;
                        end else if (w_b == shp_pkg::OP_PROG) begin
                            n_cmd = shp_pkg::CMD_PROG;
                        end else if (w_b == shp_pkg::OP_VELO) begin
                            n_cmd = shp_pkg::CMD_VELO;
                        end else begin
                            n_cmd = shp_pkg::CMD_NONE;
                        end
                    end
                end
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            shp_pkg::ST_IDLE: begin
                if (w_accept && w_div) begin
                    n_state = shp_pkg::ST_DIV;
                end
            end
            shp_pkg::ST_DIV: begin
                if (w_div_stat.done && w_slot_free) begin
                    n_state = shp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_ready     = 1'b0;
        w_load_div  = 1'b0;
        case (r_state)
            shp_pkg::ST_IDLE: begin
                w_ready = w_slot_free;
            end
            shp_pkg::ST_DIV: begin
                w_load_div = w_div_stat.done && w_slot_free;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    assign w_div_start = w_accept && w_div;
    assign w_load_step = w_accept && w_emit && !w_div;

    shp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_b),
        .o_quotient (w_quot),
        .o_stat     (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shp_pkg::ST_IDLE;
            r_active   <= 1'b0;
            r_at_first <= 1'b0;
            r_cmd      <= shp_pkg::CMD_NONE;
            r_pos      <= '0;
            r_vol      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_active   <= n_active;
                r_at_first <= n_at_first;
                r_cmd      <= n_cmd;
                r_pos      <= n_pos;
                r_vol      <= n_vol;
            end
            if (w_load_step || w_load_div) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_tempo <= w_b;
        end
        if (w_load_step) begin
            r_o_code  <= w_code;
            r_o_value <= w_value;
            r_o_ticks <= '0;
            r_o_tz    <= w_tz;
            r_o_vol   <= n_vol;
        end else if (w_load_div) begin
            r_o_code  <= shp_pkg::EV_TEMPO;
            r_o_value <= r_tempo;
            r_o_ticks <= w_quot;
            r_o_tz    <= 1'b0;
            r_o_vol   <= r_vol;
        end
    end

    assign i_in.ready           = w_ready;
    assign o_out.valid          = r_o_valid;
    assign o_out.event_code     = r_o_code;
    assign o_out.value          = r_o_value;
    assign o_out.ticks_per_beat = r_o_ticks;
    assign o_out.tempo_zero     = r_o_tz;
    assign o_out.volume_bucket  = r_o_vol;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == shp_pkg::ST_IDLE |-> !w_div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_tz_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.tempo_zero |->
            o_out.event_code == shp_pkg::EV_TEMPO && o_out.ticks_per_beat == '0)
        else $error("tempo_zero outside a zero tempo event");

    a_ticks_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ticks_per_beat != '0 |-> o_out.event_code == shp_pkg::EV_TEMPO)
        else $error("ticks_per_beat set outside a tempo event");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd == shp_pkg::CMD_NONE |-> r_pos == 2'd0)
        else $error("payload position set with no record held");
endmodule

### hdl/shp_div.sv
`timescale 1ns / 1ps
// Restoring divider: TICK_BASE / divisor, one quotient bit per cycle.
// Depends on shp_pkg; the quotient holds until the next start.
module shp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [shp_pkg::BYTE_W-1:0]  i_divisor,
    output logic [shp_pkg::TICKS_W-1:0] o_quotient,
    output shp_pkg::t_div_stat          o_stat
);
    localparam int CNT_W = $clog2(shp_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(shp_pkg::DIV_STEPS - 1);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [shp_pkg::TICKS_W-1:0] r_work, n_work;
    logic [shp_pkg::BYTE_W-1:0]  r_rem, n_rem;
    logic [shp_pkg::BYTE_W-1:0]  r_div, n_div;
    logic [shp_pkg::BYTE_W:0]    w_trial;
    logic [shp_pkg::BYTE_W:0]    w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_work[shp_pkg::TICKS_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_work = shp_pkg::TICK_BASE;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[shp_pkg::BYTE_W-1:0] : w_trial[shp_pkg::BYTE_W-1:0];
            n_work = {r_work[shp_pkg::TICKS_W-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_quotient  = r_work;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for song_header_command_parser: directed table, then random headers with idle gaps.
// Depends on shp_pkg, shp_in_if, shp_out_if and the parser RTL.
module tb_top;

    typedef struct packed {
        shp_pkg::t_event                code;
        logic [shp_pkg::BYTE_W-1:0]     value;
        logic [shp_pkg::TICKS_W-1:0]    ticks;
        logic                           zero_tempo;
        logic [shp_pkg::VOL_W-1:0]      bucket;
    } t_hdr_event;

    typedef struct packed {
        logic        typed;
        logic        has;
        t_hdr_event  ev;
    } t_item_note;

    typedef struct packed {
        logic [shp_pkg::BYTE_W-1:0] hbyte;
        logic                       first_flag;
        logic                       typed;
        logic                       has;
        t_hdr_event                 ev;
    } t_dir_row;

    localparam t_hdr_event NO_EV = '{shp_pkg::EV_END, 8'h00, 12'd0, 1'b0, 4'd0};
    localparam int DIR_ROWS = 28;
    localparam int RANDOM_ITEMS = 1550;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shp_in_if  byte_ch ();
    shp_out_if event_ch ();

    song_header_command_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (event_ch)
    );

    always #5 i_clk = ~i_clk;

    t_hdr_event expected_events [$];
    t_item_note item_notes [$];
    t_item_note no_note = '{1'b0, 1'b0, NO_EV};
    int         mismatches = 0;
    int         items_fed = 0;
    bit         calm = 1'b0;
    bit         next_first = 1'b0;

    logic                        hdr_on = 1'b0;
    logic                        at_lead = 1'b0;
    shp_pkg::t_cmd               rec_kind = shp_pkg::CMD_NONE;
    logic [1:0]                  rec_pos = 2'd0;
    logic [shp_pkg::VOL_W-1:0]   vb_held = '0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_EV},
        '{shp_pkg::OP_CHAN, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'hAA, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_CHAN, 8'hFF, 12'd0, 1'b0, 4'd0}},
        '{shp_pkg::OP_TEMPO, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_TEMPO, 8'h00, 12'd0, 1'b1, 4'd0}},
        '{shp_pkg::OP_TEMPO, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h01, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_TEMPO, 8'h01, 12'd2400, 1'b0, 4'd0}},
        '{shp_pkg::OP_VELO, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h16, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_VELO, 8'h16, 12'd0, 1'b0, 4'd5}},
        '{shp_pkg::OP_VELO, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_VELO, 8'hFF, 12'd0, 1'b0, 4'd5}},
        '{shp_pkg::OP_VOL, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h55, 1'b0, 1'b0, 1'b0, NO_EV},
        '{shp_pkg::OP_PROG, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h01, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'h1F, 1'b0, 1'b0, 1'b0, NO_EV},
        '{shp_pkg::OP_TEMPO, 1'b1, 1'b0, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_TEMPO, 8'hFF, 12'd9, 1'b0, 4'd5}},
        '{8'h82, 1'b0, 1'b0, 1'b0, NO_EV},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_END, 8'h00, 12'd0, 1'b0, 4'd5}},
        '{shp_pkg::OP_CHAN, 1'b0, 1'b1, 1'b0, NO_EV},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_EV},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{shp_pkg::EV_END, 8'h00, 12'd0, 1'b0, 4'd5}},
        '{8'hFF, 1'b1, 1'b1, 1'b1, '{shp_pkg::EV_END, 8'h00, 12'd0, 1'b0, 4'd5}}
    };

    function automatic void parse_header_byte(input logic [shp_pkg::BYTE_W-1:0] b,
                                              input logic f,
                                              output logic has, output t_hdr_event ev);
        shp_pkg::t_cmd              rec;
        logic [shp_pkg::BYTE_W-1:0] m;
        has = 1'b0;
        ev = NO_EV;
        if (f) begin
            hdr_on = 1'b1;
            at_lead = 1'b1;
            rec_kind = shp_pkg::CMD_NONE;
            rec_pos = 2'd0;
        end
        if (!hdr_on)
            return;
        if (rec_kind != shp_pkg::CMD_NONE) begin
            rec = rec_kind;
            rec_pos = rec_pos + 2'd1;
            if (rec_pos + 1 < ((rec == shp_pkg::CMD_TEMPO || rec == shp_pkg::CMD_VOL) ? 2 : 3))
                return;
            rec_kind = shp_pkg::CMD_NONE;
            rec_pos = 2'd0;
            case (rec)
                shp_pkg::CMD_CHAN: begin
                    has = 1'b1;
                    ev.code = shp_pkg::EV_CHAN;
                    ev.value = b;
                end
                shp_pkg::CMD_TEMPO: begin
                    has = 1'b1;
                    ev.code = shp_pkg::EV_TEMPO;
                    ev.value = b;
                    if (b == shp_pkg::BYTE_ZERO)
                        ev.zero_tempo = 1'b1;
                    else
                        ev.ticks = shp_pkg::TICK_BASE / b;
                end
                shp_pkg::CMD_VELO: begin
                    if (b < shp_pkg::VEL_T0)      vb_held = shp_pkg::VB_0;
                    else if (b < shp_pkg::VEL_T1) vb_held = shp_pkg::VB_1;
                    else if (b < shp_pkg::VEL_T2) vb_held = shp_pkg::VB_2;
                    else if (b < shp_pkg::VEL_T3) vb_held = shp_pkg::VB_3;
                    else if (b < shp_pkg::VEL_T4) vb_held = shp_pkg::VB_4;
                    has = 1'b1;
                    ev.code = shp_pkg::EV_VELO;
                    ev.value = b;
                end
                default: ;
            endcase
            ev.bucket = vb_held;
            return;
        end
        if (at_lead) begin
            at_lead = 1'b0;
            if (b == shp_pkg::BYTE_ZERO)
                return;
        end
        if (b == shp_pkg::BYTE_ZERO || b == shp_pkg::BYTE_END) begin
            hdr_on = 1'b0;
            rec_kind = shp_pkg::CMD_NONE;
            rec_pos = 2'd0;
            has = 1'b1;
            ev.bucket = vb_held;
            return;
        end
        m = b & shp_pkg::NOTE_MASK;
        if (m != 0 && m < shp_pkg::NOTE_LIMIT)
            rec_kind = shp_pkg::CMD_NOTE;
        else begin
            case (b)
                shp_pkg::OP_CHAN:  rec_kind = shp_pkg::CMD_CHAN;
                shp_pkg::OP_TEMPO: rec_kind = shp_pkg::CMD_TEMPO;
                shp_pkg::OP_VOL:   rec_kind = shp_pkg::CMD_VOL;
                shp_pkg::OP_PROG:  rec_kind = shp_pkg::CMD_PROG;
                shp_pkg::OP_VELO:  rec_kind = shp_pkg::CMD_VELO;
                default:           rec_kind = shp_pkg::CMD_NONE;
            endcase
        end
        rec_pos = 2'd0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_event(input t_hdr_event got);
        t_hdr_event want;
        if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event code %0d with nothing pending", got.code));
            return;
        end
        want = expected_events.pop_front();
        if (got.code !== want.code)
            report_mismatch($sformatf("event_code got %0d want %0d", got.code, want.code));
        if (got.value !== want.value)
            report_mismatch($sformatf("value got %0h want %0h", got.value, want.value));
        if (got.ticks !== want.ticks)
            report_mismatch($sformatf("ticks_per_beat got %0d want %0d", got.ticks, want.ticks));
        if (got.zero_tempo !== want.zero_tempo)
            report_mismatch($sformatf("tempo_zero got %0b want %0b",
                                      got.zero_tempo, want.zero_tempo));
        if (got.bucket !== want.bucket)
            report_mismatch($sformatf("volume_bucket got %0d want %0d", got.bucket, want.bucket));
    endtask

    always @(posedge i_clk) begin : event_watch
        t_hdr_event pred;
        logic       pred_has;
        t_item_note note;
        if (i_rst_n) begin
            if (event_ch.valid && event_ch.ready)
                check_event('{event_ch.event_code, event_ch.value, event_ch.ticks_per_beat,
                              event_ch.tempo_zero, event_ch.volume_bucket});
            if (byte_ch.valid && byte_ch.ready) begin
                parse_header_byte(byte_ch.header_byte, byte_ch.first, pred_has, pred);
                note = item_notes.pop_front();
                if (note.typed) begin
                    pred_has = note.has;
                    pred = note.ev;
                end
                if (pred_has)
                    expected_events.push_back(pred);
            end
        end
    end

    initial begin : event_sink
        int stall;
        event_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                event_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            event_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!event_ch.valid);
        end
    end

    task automatic drive_byte(input logic [shp_pkg::BYTE_W-1:0] b, input logic f,
                              input t_item_note note);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_notes.push_back(note);
        byte_ch.valid       <= 1'b1;
        byte_ch.header_byte <= b;
        byte_ch.first       <= f;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic feed(input logic [shp_pkg::BYTE_W-1:0] b, input logic f);
        drive_byte(b, f | next_first, no_note);
        next_first = 1'b0;
        items_fed++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [shp_pkg::BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return shp_pkg::BYTE_ZERO;
            1:       return shp_pkg::BYTE_END;
            default: return shp_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_header();
        logic [shp_pkg::BYTE_W-1:0] thr [5];
        logic [shp_pkg::BYTE_W-1:0] b;
        int                         n_rec;
        int                         kind;
        thr = '{shp_pkg::VEL_T0, shp_pkg::VEL_T1, shp_pkg::VEL_T2, shp_pkg::VEL_T3,
                shp_pkg::VEL_T4};
        next_first = 1'b1;
        if ($urandom_range(0, 1))
            feed(shp_pkg::BYTE_ZERO, 1'b1);
        n_rec = $urandom_range(0, 12);
        repeat (n_rec) begin
            kind = $urandom_range(0, 99);
            if (kind < 14) begin
                feed(shp_pkg::OP_CHAN, 1'b0);
                feed(payload_byte(), 1'b0);
                feed(payload_byte(), 1'b0);
            end else if (kind < 30) begin
                feed(shp_pkg::OP_TEMPO, 1'b0);
                case ($urandom_range(0, 9))
                    0:       feed(shp_pkg::BYTE_ZERO, 1'b0);
                    1:       feed(shp_pkg::BYTE_W'($urandom_range(1, 3)), 1'b0);
                    default: feed(payload_byte(), 1'b0);
                endcase
            end else if (kind < 38) begin
                feed(shp_pkg::OP_VOL, 1'b0);
                feed(payload_byte(), 1'b0);
            end else if (kind < 46) begin
                feed(shp_pkg::OP_PROG, 1'b0);
                feed(payload_byte(), 1'b0);
                feed(payload_byte(), 1'b0);
            end else if (kind < 64) begin
                feed(shp_pkg::OP_VELO, 1'b0);
                feed(payload_byte(), 1'b0);
                if ($urandom_range(0, 1))
                    feed(thr[$urandom_range(0, 4)] - shp_pkg::BYTE_W'($urandom_range(0, 1)),
                         1'b0);
                else
                    feed(payload_byte(), 1'b0);
            end else if (kind < 80) begin
                feed({1'b0, 2'($urandom_range(0, 3)), 5'($urandom_range(1, 31))}, 1'b0);
                feed(payload_byte(), 1'b0);
                feed(payload_byte(), 1'b0);
            end else if (kind < 90) begin
                do b = shp_pkg::BYTE_W'($urandom_range(0, 255));
                while (b == shp_pkg::BYTE_ZERO || b == shp_pkg::BYTE_END ||
                       b == shp_pkg::OP_CHAN || b == shp_pkg::OP_TEMPO ||
                       b == shp_pkg::OP_VOL || b == shp_pkg::OP_PROG || b == shp_pkg::OP_VELO ||
                       ((b & shp_pkg::NOTE_MASK) != 0 &&
                        (b & shp_pkg::NOTE_MASK) < shp_pkg::NOTE_LIMIT));
                feed(b, 1'b0);
            end else if (kind < 95) begin
                feed(shp_pkg::BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end else begin
                // cut a record short; the next header starts mid record
                feed($urandom_range(0, 1) ? shp_pkg::OP_CHAN : shp_pkg::OP_VELO, 1'b0);
                feed(payload_byte(), 1'b0);
                return;
            end
        end
        if ($urandom_range(0, 9) == 0)
            return;
        feed($urandom_range(0, 1) ? shp_pkg::BYTE_END : shp_pkg::BYTE_ZERO, 1'b0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                drive_byte(shp_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, no_note);
    endtask

    initial begin : stimulus
        int         row;
        int         hdr_count;
        t_item_note note;
        byte_ch.valid       <= 1'b0;
        byte_ch.header_byte <= '0;
        byte_ch.first       <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (row = 0; row < DIR_ROWS; row++) begin
            note = '{dir_rows[row].typed, dir_rows[row].has, dir_rows[row].ev};
            drive_byte(dir_rows[row].hbyte, dir_rows[row].first_flag, note);
        end
        hdr_count = 0;
        while (items_fed < RANDOM_ITEMS) begin
            calm = (hdr_count % 10) >= 8;
            if (hdr_count == 40)
                wait_drained();
            random_header();
            hdr_count++;
        end
        calm = 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hdl/shp_pkg.sv
hdl/shp_in_if.sv
hdl/shp_out_if.sv
hdl/shp_div.sv
hdl/song_header_command_parser.sv
sim/tb_top.sv
